// ===== design/gtg_pkg.sv =====
// Shared types, constants and the arctangent table of the go-to-goal steering controller.
package gtg_pkg;

  // Number of rotation steps of the vectoring pass, and the upper limit that bounds it.
  localparam int CORDIC_ITERATIONS = 16;
  localparam int MAX_STEPS         = 24;
  localparam int NUM_STEPS = (CORDIC_ITERATIONS < MAX_STEPS) ? CORDIC_ITERATIONS : MAX_STEPS;
  localparam int STEP_W            = $clog2(MAX_STEPS);

  // Field and datapath widths.
  localparam int COORD_W   = 16;  // goal and pose positions, unsigned Q4.12
  localparam int HEAD_W    = 15;  // heading, signed Q3.12
  localparam int TURN_W    = 14;  // turn rate, signed Q.12
  localparam int SPEED_W   = 13;  // forward speed, unsigned Q.12
  localparam int VEC_W     = 28;  // rotating vector components, signed Q.20
  localparam int ANG_W     = 24;  // angle accumulator, signed Q.20
  localparam int ATAN_W    = 20;  // arctangent table entries, Q.20
  localparam int BEAR_W    = 16;  // bearing, signed Q.12
  localparam int GAIN_W    = 30;  // inverse CORDIC gain, Q.30
  localparam int PROD_W    = VEC_W - 1 + GAIN_W;
  localparam int DIST_W    = PROD_W + 1 - 38;
  localparam int TDATA_IN_W  = 48;
  localparam int TDATA_OUT_W = 32;

  // Fixed-point constants.
  localparam logic [ANG_W-1:0]  HALF_PI_Q20   = ANG_W'(1647099);
  localparam logic [GAIN_W-1:0] GAIN_INV_Q30  = GAIN_W'(652032874);
  localparam logic [DIST_W-1:0] NEAR_Q12      = DIST_W'(819);
  localparam int                TURN_SLOW_Q12 = 819;
  localparam int                ONE_Q12       = 4096;
  localparam logic [SPEED_W-1:0] CRAWL_Q12    = SPEED_W'(41);

  // Register select (address bit 2 of the configuration port).
  localparam logic REG_GOAL_X = 1'b0;
  localparam logic REG_GOAL_Y = 1'b1;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ITER,
    ST_SCALE,
    ST_FINISH
  } state_t;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic              load;
    logic              step;
    logic [STEP_W-1:0] step_idx;
    logic              scale;
    logic              commit;
  } gtg_cmd_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic out_hold;
  } gtg_stat_t;

  // atan(2^-i) in Q.20, zero beyond the table.
  function automatic logic [ATAN_W-1:0] atan_q20(input logic [STEP_W-1:0] idx);
    logic [ATAN_W-1:0] val;
    unique case (idx)
      5'd0:  val = 20'd823550;
      5'd1:  val = 20'd486170;
      5'd2:  val = 20'd256879;
      5'd3:  val = 20'd130396;
      5'd4:  val = 20'd65451;
      5'd5:  val = 20'd32757;
      5'd6:  val = 20'd16383;
      5'd7:  val = 20'd8192;
      5'd8:  val = 20'd4096;
      5'd9:  val = 20'd2048;
      5'd10: val = 20'd1024;
      5'd11: val = 20'd512;
      5'd12: val = 20'd256;
      5'd13: val = 20'd128;
      5'd14: val = 20'd64;
      5'd15: val = 20'd32;
      5'd16: val = 20'd16;
      5'd17: val = 20'd8;
      5'd18: val = 20'd4;
      5'd19: val = 20'd2;
      5'd20: val = 20'd1;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

// ===== design/go_to_goal_steering_controller_core.sv =====
// Top level of the go-to-goal steering controller: stream ports, APB registers, sequencer, datapath.
//
//  Channel   Direction  Beat contents
//  s_axis    in         pose_x, pose_y, pose_heading in tdata
//  m_axis    out        turn_rate, forward_speed in tdata; goal_reached in tuser
//  apb       in/out     goal_x at 0x0, goal_y at 0x4
//
// Each pose takes an accept step, the CORDIC rotation steps (one step of the shared
// shift-add unit per cycle), a scaling step for the gain multiplier and a finish step;
// a new pose is taken only after the finish step of the last one.
// Reset is synchronous; it clears the goal, the held commands and the sequencer.
// A stalled result sits in the output register while the next pose is already taken;
// the finish cycle waits only if that register is still full.
module go_to_goal_steering_controller_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [gtg_pkg::TDATA_IN_W-1:0]    s_axis_tdata,   // pose_x [15:0], pose_y [31:16], pose_heading [46:32]
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [gtg_pkg::TDATA_OUT_W-1:0]   m_axis_tdata,   // turn_rate [13:0], forward_speed [26:14]
  output logic [0:0]                        m_axis_tuser,   // goal_reached [0]
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [2:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  logic [gtg_pkg::COORD_W-1:0]              goal_x, goal_y;
  gtg_pkg::gtg_cmd_t                        cmd;
  gtg_pkg::gtg_stat_t                       stat;
  logic signed [gtg_pkg::TURN_W-1:0]        turn_rate;
  logic [gtg_pkg::SPEED_W-1:0]              forward_speed;
  logic                                     goal_reached;

  gtg_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .goal_x  (goal_x),
    .goal_y  (goal_y)
  );

  gtg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  gtg_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .goal_x        (goal_x),
    .goal_y        (goal_y),
    .pose_x        (s_axis_tdata[15:0]),
    .pose_y        (s_axis_tdata[31:16]),
    .pose_heading  ($signed(s_axis_tdata[46:32])),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .turn_rate     (turn_rate),
    .forward_speed (forward_speed),
    .goal_reached  (goal_reached)
  );

  assign m_axis_tdata = {5'b0, forward_speed, turn_rate};
  assign m_axis_tuser = goal_reached;

  // One pose at a time: after a beat is taken the input stays closed for the pass.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted again during a CORDIC pass");

  // The turn command never leaves the clamp range.
  a_turn_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (turn_rate <= 14'sd4096 && turn_rate >= -14'sd4096))
    else $error("turn rate outside plus or minus one");

  // A fresh command with a sharp turn must crawl.
  a_crawl: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !goal_reached && (turn_rate > 14'sd819 || turn_rate < -14'sd819)
    |-> forward_speed == gtg_pkg::CRAWL_Q12)
    else $error("sharp turn without crawl speed");

  // A result is only committed in the finish step of a pass, never over a waiting beat.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !(m_axis_tvalid && !m_axis_tready))
    else $error("result committed over a stalled beat");

endmodule

// ===== design/gtg_regs.sv =====
// Configuration register file holding the goal position, written and read over the APB port.
module gtg_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output logic [gtg_pkg::COORD_W-1:0] goal_x,
  output logic [gtg_pkg::COORD_W-1:0] goal_y
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // Register writes in the access phase; bit 2 of the address selects the register.
  always_ff @(posedge clk) begin
    if (rst) begin
      goal_x <= '0;
      goal_y <= '0;
    end else if (wr_en) begin
      unique case (paddr[2])
        gtg_pkg::REG_GOAL_X: goal_x <= pwdata[gtg_pkg::COORD_W-1:0];
        gtg_pkg::REG_GOAL_Y: goal_y <= pwdata[gtg_pkg::COORD_W-1:0];
        default: ;
      endcase
    end
  end

  // Read data, zero extended.
  always_comb begin
    unique case (paddr[2])
      gtg_pkg::REG_GOAL_X: prdata = {16'b0, goal_x};
      gtg_pkg::REG_GOAL_Y: prdata = {16'b0, goal_y};
      default:             prdata = '0;
    endcase
  end

endmodule

// ===== design/gtg_ctrl.sv =====
// Sequencer that steps the datapath through load, rotation steps, scaling and commit.
module gtg_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  gtg_pkg::gtg_stat_t  stat,
  output gtg_pkg::gtg_cmd_t   cmd
);

  gtg_pkg::state_t                 state, state_next;
  logic [gtg_pkg::STEP_W-1:0]      step_cnt;
  logic                            last_step;

  assign last_step = (step_cnt == gtg_pkg::STEP_W'(gtg_pkg::NUM_STEPS - 1));

  // State register and step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= gtg_pkg::ST_IDLE;
      step_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == gtg_pkg::ST_ITER) begin
        step_cnt <= step_cnt + 1'b1;
      end else begin
        step_cnt <= '0;
      end
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      gtg_pkg::ST_IDLE:   if (in_valid) state_next = gtg_pkg::ST_ITER;
      gtg_pkg::ST_ITER:   if (last_step) state_next = gtg_pkg::ST_SCALE;
      gtg_pkg::ST_SCALE:  state_next = gtg_pkg::ST_FINISH;
      gtg_pkg::ST_FINISH: if (!stat.out_hold) state_next = gtg_pkg::ST_IDLE;
      default:            state_next = gtg_pkg::ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready     = 1'b0;
    cmd          = '0;
    cmd.step_idx = step_cnt;
    unique case (state)
      gtg_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      gtg_pkg::ST_ITER:   cmd.step   = 1'b1;
      gtg_pkg::ST_SCALE:  cmd.scale  = 1'b1;
      gtg_pkg::ST_FINISH: cmd.commit = !stat.out_hold;
      default: ;
    endcase
  end

endmodule

// ===== design/gtg_dp.sv =====
// Datapath: offset, CORDIC vectoring unit, gain scaling, command logic and output register.
module gtg_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  gtg_pkg::gtg_cmd_t             cmd,
  output gtg_pkg::gtg_stat_t            stat,
  input  logic [gtg_pkg::COORD_W-1:0]   goal_x,
  input  logic [gtg_pkg::COORD_W-1:0]   goal_y,
  input  logic [gtg_pkg::COORD_W-1:0]   pose_x,
  input  logic [gtg_pkg::COORD_W-1:0]   pose_y,
  input  logic signed [gtg_pkg::HEAD_W-1:0] pose_heading,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [gtg_pkg::TURN_W-1:0] turn_rate,
  output logic [gtg_pkg::SPEED_W-1:0]   forward_speed,
  output logic                          goal_reached
);

  localparam int VW = gtg_pkg::VEC_W;
  localparam int AW = gtg_pkg::ANG_W;

  // Working registers.
  logic signed [VW-1:0]                  cx, cy;
  logic signed [AW-1:0]                  cz;
  logic signed [gtg_pkg::HEAD_W-1:0]     head;
  logic [gtg_pkg::PROD_W-1:0]            prod;
  logic signed [gtg_pkg::BEAR_W-1:0]     bearing;
  logic signed [gtg_pkg::TURN_W-1:0]     held_turn_rate;
  logic [gtg_pkg::SPEED_W-1:0]           held_forward_speed;

  // Load values.
  logic signed [gtg_pkg::COORD_W:0]      dx, dy;
  logic signed [VW-1:0]                  x0, y0, lx, ly;
  logic signed [AW-1:0]                  lz;

  // Step values.
  logic signed [VW-1:0]                  xs, ys;
  logic signed [AW-1:0]                  atan_ext;

  // Scale and finish values.
  logic [VW-2:0]                         xpos;
  logic signed [AW-1:0]                  z_rnd;
  logic [gtg_pkg::PROD_W:0]              dist_sum;
  logic [gtg_pkg::DIST_W-1:0]            goal_dist;
  logic                                  near;
  logic signed [gtg_pkg::BEAR_W:0]       turn_raw;
  logic signed [gtg_pkg::TURN_W-1:0]     turn;
  logic [gtg_pkg::SPEED_W-1:0]           speed;

  // Offset to the goal in Q.20, turned into the right half plane when it points left.
  always_comb begin
    dx = $signed({1'b0, goal_x}) - $signed({1'b0, pose_x});
    dy = $signed({1'b0, goal_y}) - $signed({1'b0, pose_y});
    x0 = {{(VW-gtg_pkg::COORD_W-9){dx[gtg_pkg::COORD_W]}}, dx, 8'b0};
    y0 = {{(VW-gtg_pkg::COORD_W-9){dy[gtg_pkg::COORD_W]}}, dy, 8'b0};
    lx = x0;
    ly = y0;
    lz = '0;
    if (x0 < 0) begin
      if (y0 >= 0) begin
        lx = y0;
        ly = -x0;
        lz = gtg_pkg::HALF_PI_Q20;
      end else begin
        lx = -y0;
        ly = x0;
        lz = -gtg_pkg::HALF_PI_Q20;
      end
    end
  end

  // One rotation step per cycle; a component of zero counts as positive.
  assign xs       = cx >>> cmd.step_idx;
  assign ys       = cy >>> cmd.step_idx;
  assign atan_ext = $signed({{(AW-gtg_pkg::ATAN_W){1'b0}}, gtg_pkg::atan_q20(cmd.step_idx)});

  // Scaling inputs: the final x clipped at zero, and the bearing rounded half up to Q.12.
  assign xpos  = cx[VW-1] ? '0 : cx[VW-2:0];
  assign z_rnd = cz + AW'(128);

  // Command logic from the scaled distance and bearing.
  always_comb begin
    dist_sum  = {1'b0, prod} + ((gtg_pkg::PROD_W+1)'(1) << 37);
    goal_dist = dist_sum[gtg_pkg::PROD_W:38];
    near      = (goal_dist <= gtg_pkg::NEAR_Q12);
    turn_raw  = (gtg_pkg::BEAR_W+1)'(bearing) - (gtg_pkg::BEAR_W+1)'(head);
    if (turn_raw > (gtg_pkg::BEAR_W+1)'(gtg_pkg::ONE_Q12)) begin
      turn = gtg_pkg::TURN_W'(gtg_pkg::ONE_Q12);
    end else if (turn_raw < -(gtg_pkg::BEAR_W+1)'(gtg_pkg::ONE_Q12)) begin
      turn = -gtg_pkg::TURN_W'(gtg_pkg::ONE_Q12);
    end else begin
      turn = turn_raw[gtg_pkg::TURN_W-1:0];
    end
    if (turn > gtg_pkg::TURN_W'(gtg_pkg::TURN_SLOW_Q12) ||
        turn < -gtg_pkg::TURN_W'(gtg_pkg::TURN_SLOW_Q12)) begin
      speed = gtg_pkg::CRAWL_Q12;
    end else if (goal_dist > gtg_pkg::DIST_W'(gtg_pkg::ONE_Q12)) begin
      speed = gtg_pkg::SPEED_W'(gtg_pkg::ONE_Q12);
    end else begin
      speed = goal_dist[gtg_pkg::SPEED_W-1:0];
    end
  end

  // CORDIC and scaling registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cx   <= lx;
      cy   <= ly;
      cz   <= lz;
      head <= pose_heading;
    end else if (cmd.step) begin
      if (!cy[VW-1]) begin
        cx <= cx + ys;
        cy <= cy - xs;
        cz <= cz + atan_ext;
      end else begin
        cx <= cx - ys;
        cy <= cy + xs;
        cz <= cz - atan_ext;
      end
    end
    if (cmd.scale) begin
      prod    <= gtg_pkg::PROD_W'(xpos) * gtg_pkg::PROD_W'(gtg_pkg::GAIN_INV_Q30);
      bearing <= z_rnd[AW-1:8];
    end
  end

  // Held commands and output beat register.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_turn_rate     <= '0;
      held_forward_speed <= '0;
      out_valid          <= 1'b0;
    end else begin
      if (cmd.commit) begin
        out_valid <= 1'b1;
        if (!near) begin
          held_turn_rate     <= turn;
          held_forward_speed <= speed;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      turn_rate     <= near ? held_turn_rate : turn;
      forward_speed <= near ? held_forward_speed : speed;
      goal_reached  <= near;
    end
  end

  assign stat.out_hold = out_valid & ~out_ready;

endmodule
